@@ hw/rtl/cdda_pkg.sv @@
// ============================================================================
// cdda_pkg: shared types and constants of the calendar date day adder
// Field widths, status and mode codes, month numbers, controller/datapath
// command and status structs, and the leap year and month length helpers.
// ============================================================================
package cdda_pkg;

    // Default width of the stored year.
    localparam int YEAR_WIDTH_DEF = 16;

    // Fixed field widths of the channels.
    localparam int IN_YEAR_W = 16;
    localparam int DELTA_W   = 16;
    localparam int MON_W     = 4;
    localparam int DAY_W     = 5;
    localparam int STAT_W    = 2;

    // Width of a year residue modulo 400.
    localparam int YMOD_W = 9;
    localparam logic [YMOD_W-1:0] MOD400 = 9'd400;
    localparam logic [YMOD_W-1:0] MOD100 = 9'd100;
    localparam logic [YMOD_W-1:0] MOD200 = 9'd200;
    localparam logic [YMOD_W-1:0] MOD300 = 9'd300;

    // Mode codes.
    localparam logic MODE_SET = 1'b0;
    localparam logic MODE_ADD = 1'b1;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF    = 2'd2;

    // Month numbers.
    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    // Month lengths.
    localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] LEN_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture an accepted item
        logic mod_step;  // one step of the year residue computation
        logic add_step;  // one month step of an add
        logic commit;    // update the date and load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_last;  // this residue step is the final one
        logic add_fin;   // this month step ends the add
        logic out_busy;  // output register holds a result not yet taken
    } t_stat;

    // Leap year test on the year residue modulo 400.
    function automatic logic f_leap(input logic [YMOD_W-1:0] r);
        logic by100;
        by100 = (r == '0) || (r == MOD100) || (r == MOD200) || (r == MOD300);
        return ((r[1:0] == 2'b00) && !by100) || (r == '0);
    endfunction

    // Number of days in a month.
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MON_FEB) begin
            len = leap ? LEN_FEB_LEAP : LEN_FEB;
        end else if (m inside {MON_APR, MON_JUN, MON_SEP, MON_NOV}) begin
            len = LEN_SHORT;
        end else begin
            len = LEN_LONG;
        end
        return len;
    endfunction

endpackage

@@ hw/rtl/cdda_if.sv @@
// ============================================================================
// cdda_if: request and result channels of the calendar date day adder
// Valid/ready channels; a transfer happens when valid and ready are high.
// ============================================================================
interface cdda_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic signed [cdda_pkg::IN_YEAR_W-1:0] new_year;
    logic [cdda_pkg::MON_W-1:0]         new_month;
    logic [cdda_pkg::DAY_W-1:0]         new_day;
    logic signed [cdda_pkg::DELTA_W-1:0] days_delta;

    modport source (output valid, mode, new_year, new_month, new_day, days_delta,
                    input ready);
    modport sink   (input valid, mode, new_year, new_month, new_day, days_delta,
                    output ready);
endinterface

interface cdda_out_if #(parameter int YEAR_WIDTH = cdda_pkg::YEAR_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [YEAR_WIDTH-1:0]  out_year;
    logic [cdda_pkg::MON_W-1:0]    out_month;
    logic [cdda_pkg::DAY_W-1:0]    out_day;
    logic [cdda_pkg::STAT_W-1:0]   status;

    modport source (output valid, out_year, out_month, out_day, status, input ready);
    modport sink   (input valid, out_year, out_month, out_day, status, output ready);
endinterface

@@ hw/rtl/cdda_ctrl.sv @@
// ============================================================================
// cdda_ctrl: sequencer of the calendar date day adder
// Accepts a request, runs the year residue division or the month steps in
// the datapath, and commits the result once the output register is free.
// ============================================================================
module cdda_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_mode,
    input  cdda_pkg::t_stat i_stat,
    output cdda_pkg::t_cmd  o_cmd
);
    import cdda_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_mode == MODE_ADD) ? S_ADD : S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_DONE;
                end
            end
            S_ADD: begin
                o_cmd.add_step = 1'b1;
                if (i_stat.add_fin) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/cdda_dp.sv @@
// ============================================================================
// cdda_dp: datapath of the calendar date day adder
// Stored date, a reciprocal remainder unit for the year modulo 400,
// the month stepper for adds, and the output register.
// ============================================================================
module cdda_dp #(
    parameter int YEAR_WIDTH = cdda_pkg::YEAR_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cdda_pkg::t_cmd                       i_cmd,
    output cdda_pkg::t_stat                      o_stat,
    input  logic                                 i_mode,
    input  logic signed [cdda_pkg::IN_YEAR_W-1:0] i_new_year,
    input  logic [cdda_pkg::MON_W-1:0]           i_new_month,
    input  logic [cdda_pkg::DAY_W-1:0]           i_new_day,
    input  logic signed [cdda_pkg::DELTA_W-1:0]  i_days_delta,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [YEAR_WIDTH-1:0]         o_out_year,
    output logic [cdda_pkg::MON_W-1:0]           o_out_month,
    output logic [cdda_pkg::DAY_W-1:0]           o_out_day,
    output logic [cdda_pkg::STAT_W-1:0]          o_out_status
);
    import cdda_pkg::*;

    // Width of the remaining day count and of the year magnitude.
    localparam int NW    = DELTA_W + 2;
    localparam int MAG_W = IN_YEAR_W + 1;
    localparam int WIDE  = 33;

    // Remainder modulo 400 = 16 * 25: the low four bits pass through and the
    // upper part is reduced modulo 25 with a reciprocal multiplication.
    localparam int LOW_W  = 4;
    localparam int HI_W   = MAG_W - LOW_W;
    localparam int R25_W  = YMOD_W - LOW_W;
    localparam int Q_W    = 9;
    localparam int RCP_W  = 11;
    localparam int PROD_W = HI_W + RCP_W;
    localparam int RCP_SH = PROD_W - Q_W;
    localparam logic [RCP_W-1:0] RCP25 = 11'd1311;
    localparam logic [HI_W-1:0]  DIV25 = HI_W'(25);

    localparam logic signed [YEAR_WIDTH-1:0] YMAX =
        {1'b0, {(YEAR_WIDTH-1){1'b1}}};
    localparam logic signed [YEAR_WIDTH-1:0] YNEG =
        {1'b1, {(YEAR_WIDTH-2){1'b0}}, 1'b1};
    localparam logic signed [YEAR_WIDTH-1:0] YR_ONE =
        {{(YEAR_WIDTH-1){1'b0}}, 1'b1};
    localparam logic signed [YEAR_WIDTH-1:0] YR_NEG_ONE = '1;
    localparam logic signed [WIDE-1:0] YMAX_W =
        {{(WIDE-YEAR_WIDTH){1'b0}}, YMAX};
    localparam logic signed [WIDE-1:0] YNEG_W = -YMAX_W;
    localparam logic signed [NW:0] SUM_ONE = {{NW{1'b0}}, 1'b1};

    // Stored date with its year residue modulo 400.
    logic signed [YEAR_WIDTH-1:0] r_date_y;
    logic [MON_W-1:0]             r_date_m;
    logic [DAY_W-1:0]             r_date_d;
    logic [YMOD_W-1:0]            r_date_ymod;

    // Captured request.
    logic                         r_mode;
    logic signed [IN_YEAR_W-1:0]  r_sy;
    logic [MON_W-1:0]             r_sm;
    logic [DAY_W-1:0]             r_sd;

    // Remainder unit.
    logic [MAG_W-1:0]             r_mag;
    logic [Q_W-1:0]               r_q;
    logic [YMOD_W-1:0]            r_rem;
    logic                         r_mph;

    // Month stepper working registers.
    logic signed [YEAR_WIDTH-1:0] r_wy;
    logic [MON_W-1:0]             r_wm;
    logic [DAY_W-1:0]             r_wd;
    logic [YMOD_W-1:0]            r_wymod;
    logic signed [NW-1:0]         r_wn;
    logic                         r_fwd;
    logic                         r_ovf;

    // Output register.
    logic                         r_ovalid;
    logic signed [YEAR_WIDTH-1:0] r_oy;
    logic [MON_W-1:0]             r_om;
    logic [DAY_W-1:0]             r_od;
    logic [STAT_W-1:0]            r_ost;

    // Year magnitude of the request.
    logic [MAG_W-1:0]  s_mag;
    logic [HI_W-1:0]   s_mag_hi;
    logic [PROD_W-1:0] s_prod;
    logic [Q_W-1:0]    s_q;
    logic [HI_W-1:0]   s_qx25;
    logic [HI_W-1:0]   s_hi_rem;
    logic [YMOD_W-1:0] s_rem_next;

    assign s_mag = i_new_year[IN_YEAR_W-1]
                 ? MAG_W'(-$signed({i_new_year[IN_YEAR_W-1], i_new_year}))
                 : MAG_W'({1'b0, i_new_year});

    // The quotient by 25 is formed and registered first, then the remainder.
    always_comb begin
        s_mag_hi   = r_mag[MAG_W-1:LOW_W];
        s_prod     = PROD_W'(s_mag_hi) * PROD_W'(RCP25);
        s_q        = s_prod[RCP_SH +: Q_W];
        s_qx25     = HI_W'(r_q) * DIV25;
        s_hi_rem   = s_mag_hi - s_qx25;
        s_rem_next = {s_hi_rem[R25_W-1:0], r_mag[LOW_W-1:0]};
    end

    // Month step arithmetic.
    logic signed [NW:0]   s_sum;
    logic signed [NW:0]   s_dim_w;
    logic signed [NW:0]   s_diff;
    logic [DAY_W-1:0]     s_dim;
    logic                 s_fin;
    logic                 s_wrap;
    logic                 s_lim;
    logic                 s_ovf;
    logic [MON_W-1:0]     s_nm;
    logic signed [YEAR_WIDTH-1:0] s_ny;
    logic [YMOD_W-1:0]    s_ystep;
    logic [YMOD_W:0]      s_ymod_try;
    logic [YMOD_W-1:0]    s_nymod;
    logic [DAY_W-1:0]     s_nlen;

    always_comb begin
        s_sum   = $signed({{(NW+1-DAY_W){1'b0}}, r_wd}) + $signed({r_wn[NW-1], r_wn});
        s_dim   = f_month_len(r_wm, f_leap(r_wymod));
        s_dim_w = $signed({{(NW+1-DAY_W){1'b0}}, s_dim});
        s_diff  = s_sum - s_dim_w;
        s_fin   = r_fwd ? (s_sum <= s_dim_w) : (s_sum >= SUM_ONE);
        s_wrap  = r_fwd ? (r_wm == MON_DEC) : (r_wm == MON_JAN);
        s_lim   = r_fwd ? (r_wy == YMAX) : (r_wy == YNEG);
        s_ovf   = !s_fin && s_wrap && s_lim;

        // Next month and year; year zero is skipped in both directions.
        if (!s_wrap) begin
            s_nm = r_fwd ? MON_W'(r_wm + 1'b1) : MON_W'(r_wm - 1'b1);
            s_ny = r_wy;
        end else if (r_fwd) begin
            s_nm = MON_JAN;
            s_ny = (r_wy == YR_NEG_ONE) ? YR_ONE : YEAR_WIDTH'(r_wy + YR_ONE);
        end else begin
            s_nm = MON_DEC;
            s_ny = (r_wy == YR_ONE) ? YR_NEG_ONE : YEAR_WIDTH'(r_wy - YR_ONE);
        end

        // Residue follows the year, stepping by two across year zero.
        if (!s_wrap) begin
            s_ystep = '0;
        end else if (r_fwd) begin
            s_ystep = (r_wy == YR_NEG_ONE) ? YMOD_W'(2) : YMOD_W'(1);
        end else begin
            s_ystep = (r_wy == YR_ONE) ? YMOD_W'(MOD400 - YMOD_W'(2))
                                       : YMOD_W'(MOD400 - YMOD_W'(1));
        end
        s_ymod_try = {1'b0, r_wymod} + {1'b0, s_ystep};
        s_nymod    = (s_ymod_try >= {1'b0, MOD400})
                   ? YMOD_W'(s_ymod_try - {1'b0, MOD400})
                   : YMOD_W'(s_ymod_try);
        s_nlen     = f_month_len(s_nm, f_leap(s_nymod));
    end

    // Validation of a set request and the date to commit.
    logic signed [WIDE-1:0]       s_sy_w;
    logic                         s_set_ok;
    logic [YMOD_W-1:0]            s_set_ymod;
    logic signed [YEAR_WIDTH-1:0] s_cy;
    logic [MON_W-1:0]             s_cm;
    logic [DAY_W-1:0]             s_cd;
    logic [YMOD_W-1:0]            s_cymod;
    logic [STAT_W-1:0]            s_cst;

    always_comb begin
        s_sy_w     = WIDE'(r_sy);
        s_set_ok   = (r_sy != '0) && (s_sy_w <= YMAX_W) && (s_sy_w >= YNEG_W) &&
                     (r_sm >= MON_JAN) && (r_sm <= MON_DEC) && (r_sd != '0) &&
                     (r_sd <= f_month_len(r_sm, f_leap(r_rem)));
        s_set_ymod = (r_sy[IN_YEAR_W-1] && (r_rem != '0)) ? YMOD_W'(MOD400 - r_rem)
                                                          : r_rem;
        s_cy    = r_date_y;
        s_cm    = r_date_m;
        s_cd    = r_date_d;
        s_cymod = r_date_ymod;
        s_cst   = ST_OK;
        if (r_mode == MODE_SET) begin
            if (s_set_ok) begin
                s_cy    = YEAR_WIDTH'(s_sy_w);
                s_cm    = r_sm;
                s_cd    = r_sd;
                s_cymod = s_set_ymod;
            end else begin
                s_cst = ST_REJECT;
            end
        end else begin
            if (r_ovf) begin
                s_cst = ST_OVF;
            end else begin
                s_cy    = r_wy;
                s_cm    = r_wm;
                s_cd    = r_wd;
                s_cymod = r_wymod;
            end
        end
    end

    // Stored date; reset to the first day of year one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date_y    <= YR_ONE;
            r_date_m    <= MON_JAN;
            r_date_d    <= DAY_W'(1);
            r_date_ymod <= YMOD_W'(1);
        end else if (i_cmd.commit) begin
            r_date_y    <= s_cy;
            r_date_m    <= s_cm;
            r_date_d    <= s_cd;
            r_date_ymod <= s_cymod;
        end
    end

    // Request capture, remainder unit and month stepper.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_sy    <= i_new_year;
            r_sm    <= i_new_month;
            r_sd    <= i_new_day;
            r_mag   <= s_mag;
            r_mph   <= 1'b0;
            r_wy    <= r_date_y;
            r_wm    <= r_date_m;
            r_wd    <= r_date_d;
            r_wymod <= r_date_ymod;
            r_wn    <= NW'(i_days_delta);
            r_fwd   <= (i_days_delta > 0);
            r_ovf   <= 1'b0;
        end
        if (i_cmd.mod_step) begin
            if (!r_mph) begin
                r_q   <= s_q;
                r_mph <= 1'b1;
            end else begin
                r_rem <= s_rem_next;
                r_mph <= 1'b0;
            end
        end
        if (i_cmd.add_step) begin
            if (s_ovf) begin
                r_ovf <= 1'b1;
            end else if (s_fin) begin
                r_wd <= s_sum[DAY_W-1:0];
            end else begin
                r_wm    <= s_nm;
                r_wy    <= s_ny;
                r_wymod <= s_nymod;
                r_wn    <= r_fwd ? $signed(s_diff[NW-1:0]) : $signed(s_sum[NW-1:0]);
                r_wd    <= r_fwd ? '0 : s_nlen;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_oy  <= s_cy;
            r_om  <= s_cm;
            r_od  <= s_cd;
            r_ost <= s_cst;
        end
    end

    // Status to the controller.
    assign o_stat.mod_last = r_mph;
    assign o_stat.add_fin  = s_fin || s_ovf;
    assign o_stat.out_busy = r_ovalid && !i_out_ready;

    assign o_out_valid  = r_ovalid;
    assign o_out_year   = r_oy;
    assign o_out_month  = r_om;
    assign o_out_day    = r_od;
    assign o_out_status = r_ost;

endmodule

@@ hw/rtl/calendar_date_day_adder_top.sv @@
// ============================================================================
// calendar_date_day_adder_top: Gregorian date holder with signed day adder
// Sets a validated date or moves the stored date by a signed day count.
// ============================================================================
//
//   Channel  Direction  Carries
//   i_in     in         mode, new_year, new_month, new_day, days_delta
//   o_out    out        out_year, out_month, out_day, status
//
// A set request first forms the year remainder modulo 400, the quotient by
// 25 and then the remainder, then is validated and committed.
// An add runs the month stepper at one month step per cycle until the day
// count is used up or the year range overflows, then commits.
// A new request is taken while a result waits in the output register; the
// commit stalls until that result is transferred. Reset gives 1-01-01.
module calendar_date_day_adder_top #(
    parameter int YEAR_WIDTH = cdda_pkg::YEAR_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdda_in_if.sink   i_in,
    cdda_out_if.source o_out
);
    import cdda_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;

    // Sequencer.
    cdda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_mode     (i_in.mode),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    // Datapath.
    cdda_dp #(
        .YEAR_WIDTH (YEAR_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_stat       (s_stat),
        .i_mode       (i_in.mode),
        .i_new_year   (i_in.new_year),
        .i_new_month  (i_in.new_month),
        .i_new_day    (i_in.new_day),
        .i_days_delta (i_in.days_delta),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_year   (o_out.out_year),
        .o_out_month  (o_out.out_month),
        .o_out_day    (o_out.out_day),
        .o_out_status (o_out.status)
    );

endmodule

@@ tb/tb_calendar_date_day_adder_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_calendar_date_day_adder_top: self-checking bench of the date day adder
// Drives set and add requests over the input channel with random gaps, pulls
// results with random stalls, and compares every result with a date
// predictor that keeps its own copy of the stored date.
// ============================================================================
module tb_calendar_date_day_adder_top;
    import cdda_pkg::*;

    localparam int YEAR_W = YEAR_WIDTH_DEF;
    localparam int YEAR_LIM = 2 ** (YEAR_W - 1) - 1;

    // One result of the block as seen on the output channel.
    typedef struct {
        logic signed [YEAR_W-1:0] year;
        logic [MON_W-1:0]         month;
        logic [DAY_W-1:0]         day;
        logic [STAT_W-1:0]        status;
    } t_date_rec;

    logic i_clk;
    logic i_rst_n;

    cdda_in_if                        in_ch ();
    cdda_out_if #(.YEAR_WIDTH(YEAR_W)) out_ch ();

    calendar_date_day_adder_top #(
        .YEAR_WIDTH(YEAR_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted stored date and the queue of results still to come.
    int        cal_year;
    int        cal_month;
    int        cal_day;
    t_date_rec pending_dates[$];
    t_date_rec want;
    int        err_cnt;
    bit        idle_en;

    // Clock.
    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // Gregorian leap rule with truncating remainders, also for negative years.
    function automatic bit leap_rule(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(input int m, input int y);
        if (m == MON_FEB) begin
            return leap_rule(y) ? 29 : 28;
        end
        if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            return 30;
        end
        return 31;
    endfunction

    // Works out the result of one request and updates the predicted date.
    function automatic t_date_rec predict_date(input logic mode,
                                               input logic signed [IN_YEAR_W-1:0] ny,
                                               input logic [MON_W-1:0] nm,
                                               input logic [DAY_W-1:0] nd,
                                               input logic signed [DELTA_W-1:0] delta);
        t_date_rec r;
        int        y;
        int        m;
        int        d;
        int        n;
        int        dim;
        bit        ovf;
        bit        done;
        r.status = ST_OK;
        if (mode == MODE_SET) begin
            y = int'(ny);
            m = int'(nm);
            d = int'(nd);
            if (y != 0 && y <= YEAR_LIM && y >= -YEAR_LIM && m >= MON_JAN &&
                m <= MON_DEC && d >= 1 && d <= month_days(m, y)) begin
                cal_year  = y;
                cal_month = m;
                cal_day   = d;
            end else begin
                r.status = ST_REJECT;
            end
        end else begin
            n    = int'(delta);
            y    = cal_year;
            m    = cal_month;
            d    = cal_day;
            ovf  = 1'b0;
            done = 1'b0;
            if (n > 0) begin
                // Forward: fill up the current month, then step to the next one.
                while (!done) begin
                    dim = month_days(m, y);
                    if (d + n <= dim) begin
                        d    = d + n;
                        done = 1'b1;
                    end else begin
                        n = d + n - dim;
                        d = 0;
                        if (m < MON_DEC) begin
                            m = m + 1;
                        end else if (y == YEAR_LIM) begin
                            ovf  = 1'b1;
                            done = 1'b1;
                        end else begin
                            m = int'(MON_JAN);
                            y = (y == -1) ? 1 : y + 1;
                        end
                    end
                end
            end else begin
                // Backward: a result at day zero rolls to the previous month end.
                while (!done) begin
                    if (d + n >= 1) begin
                        d    = d + n;
                        done = 1'b1;
                    end else begin
                        n = d + n;
                        if (m > MON_JAN) begin
                            m = m - 1;
                        end else if (y == -YEAR_LIM) begin
                            ovf  = 1'b1;
                            done = 1'b1;
                        end else begin
                            m = int'(MON_DEC);
                            y = (y == 1) ? -1 : y - 1;
                        end
                        if (!done) begin
                            d = month_days(m, y);
                        end
                    end
                end
            end
            if (ovf) begin
                r.status = ST_OVF;
            end else begin
                cal_year  = y;
                cal_month = m;
                cal_day   = d;
            end
        end
        r.year  = cal_year[YEAR_W-1:0];
        r.month = cal_month[MON_W-1:0];
        r.day   = cal_day[DAY_W-1:0];
        return r;
    endfunction

    // Sends one request and records its expected result at the transfer.
    task automatic send_req(input logic mode,
                            input logic signed [IN_YEAR_W-1:0] ny,
                            input logic [MON_W-1:0] nm,
                            input logic [DAY_W-1:0] nd,
                            input logic signed [DELTA_W-1:0] delta);
        int gap;
        gap = idle_en ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.new_year   <= ny;
        in_ch.new_month  <= nm;
        in_ch.new_day    <= nd;
        in_ch.days_delta <= delta;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_dates.push_back(predict_date(mode, ny, nm, nd, delta));
        @(negedge i_clk);
    endtask

    task automatic set_date(input int y, input int m, input int d);
        send_req(MODE_SET, y[IN_YEAR_W-1:0], m[MON_W-1:0], d[DAY_W-1:0],
                 DELTA_W'($urandom_range(0, 65535)));
    endtask

    // Add requests carry random set fields, which the block must ignore.
    task automatic shift_date(input int n);
        send_req(MODE_ADD, IN_YEAR_W'($urandom_range(0, 65535)),
                 MON_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)),
                 n[DELTA_W-1:0]);
    endtask

    // Holds off new requests until every expected result has been taken.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_dates.size() != 0);
    endtask

    // A random day count, mostly short, sometimes across years or the full range.
    function automatic int pick_delta();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return int'($urandom_range(0, 120)) - 60;
        end
        if (r < 17) begin
            return int'($urandom_range(0, 6000)) - 3000;
        end
        return int'($signed(DELTA_W'($urandom_range(0, 65535))));
    endfunction

    // A valid year, mostly near the present, sometimes at the range limits.
    function automatic int pick_year();
        int r;
        int y;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            y = $urandom_range(1, 2500);
        end else if (r < 8) begin
            y = $urandom_range(1, YEAR_LIM);
        end else begin
            y = YEAR_LIM - $urandom_range(0, 2);
        end
        return ($urandom_range(0, 1) == 1) ? -y : y;
    endfunction

    task automatic test_reset_state();
        shift_date(0);
        drain_results();
    endtask

    task automatic test_set_checks();
        set_date(2024, 2, 29);
        set_date(2023, 2, 29);
        set_date(1900, 2, 29);
        set_date(2000, 2, 29);
        set_date(-4, 2, 29);
        set_date(-1, 2, 29);
        set_date(0, 6, 1);
        set_date(-32768, 1, 1);
        set_date(5, 0, 1);
        set_date(5, 15, 31);
        set_date(5, 4, 31);
        set_date(5, 1, 0);
        drain_results();
    endtask

    task automatic test_add_edges();
        // Overflow at both ends of the year range leaves the date unchanged.
        set_date(YEAR_LIM, 12, 31);
        shift_date(1);
        set_date(-YEAR_LIM, 1, 1);
        shift_date(-1);
        // The missing year zero is skipped in both directions.
        set_date(1, 1, 1);
        shift_date(-1);
        shift_date(1);
        // A step back that reaches day zero lands on the end of February.
        set_date(2024, 3, 15);
        shift_date(-15);
        shift_date(32767);
        shift_date(-32768);
        drain_results();
    endtask

    // Mostly valid sets and adds, with some rejected sets mixed in.
    task automatic test_random_walk(input int count);
        int kind;
        int y;
        int m;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                y = pick_year();
                m = $urandom_range(1, 12);
                set_date(y, m, $urandom_range(1, month_days(m, y)));
            end else if (kind < 9) begin
                shift_date(pick_delta());
            end else begin
                set_date(int'($signed(IN_YEAR_W'($urandom_range(0, 65535)))),
                         $urandom_range(0, 15), $urandom_range(0, 31));
            end
        end
        drain_results();
    endtask

    // Fully random fields on every request.
    task automatic test_random_noise(input int count);
        for (int i = 0; i < count; i++) begin
            send_req(1'($urandom_range(0, 1)), IN_YEAR_W'($urandom_range(0, 65535)),
                     MON_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)),
                     DELTA_W'(pick_delta()));
        end
        drain_results();
    endtask

    // Requests and results back to back with no idle cycles on either side.
    task automatic test_back_to_back(input int count);
        idle_en = 1'b0;
        test_random_walk(count);
        idle_en = 1'b1;
    endtask

    // Result side: random stalls before each transfer.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = idle_en ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Compares each result transfer with the oldest expected date.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_dates.size() == 0) begin
                $error("result with no request outstanding: %0d-%0d-%0d status %0d",
                       out_ch.out_year, out_ch.out_month, out_ch.out_day, out_ch.status);
                err_cnt++;
            end else begin
                want = pending_dates.pop_front();
                if (out_ch.out_year !== want.year) begin
                    $error("out_year: expected %0d, got %0d", want.year, out_ch.out_year);
                    err_cnt++;
                end
                if (out_ch.out_month !== want.month) begin
                    $error("out_month: expected %0d, got %0d", want.month, out_ch.out_month);
                    err_cnt++;
                end
                if (out_ch.out_day !== want.day) begin
                    $error("out_day: expected %0d, got %0d", want.day, out_ch.out_day);
                    err_cnt++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_ch.status);
                    err_cnt++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        err_cnt          = 0;
        idle_en          = 1'b1;
        cal_year         = 1;
        cal_month        = 1;
        cal_day          = 1;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_SET;
        in_ch.new_year   = '0;
        in_ch.new_month  = '0;
        in_ch.new_day    = '0;
        in_ch.days_delta = '0;
        out_ch.ready     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_set_checks();
        test_add_edges();
        test_random_walk(330);
        test_back_to_back(60);
        test_random_noise(120);

        // Allow time for any stray result after the last expected one.
        drain_results();
        repeat (40) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cdda_pkg.sv
hw/rtl/cdda_if.sv
hw/rtl/cdda_ctrl.sv
hw/rtl/cdda_dp.sv
hw/rtl/calendar_date_day_adder_top.sv
tb/tb_calendar_date_day_adder_top.sv
